>>> rtl/arrt_pkg.sv
// Package: sizes, codes, control word layout and microprogram of the range table.
package arrt_pkg;

    // Table and field sizes
    localparam int ENTRIES   = 16;
    localparam int ADDR_BITS = 48;
    localparam int LEN_BITS  = 40;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int KEY_W     = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int FSLOT_W   = 4;
    localparam int PC_W      = 3;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((ADDR_BITS + LEN_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_W + 1 + ADDR_BITS + LEN_BITS + FSLOT_W + 7) / 8) * 8;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADARG   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INUSE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADSIZE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

    // Datapath micro-operations
    typedef enum logic [2:0] {
        UOP_NONE    = 3'd0,
        UOP_CLEAR   = 3'd1,
        UOP_SCAN    = 3'd2,
        UOP_RESOLVE = 3'd3,
        UOP_COMMIT  = 3'd4
    } uop_t;

    // Branch conditions
    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NO_ITEM   = 3'd2,
        COND_BAD_REQ   = 3'd3,
        COND_SCAN_MORE = 3'd4,
        COND_OUT_FULL  = 3'd5
    } cond_t;

    // One control word per microprogram step
    typedef struct packed {
        logic            take;
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Condition flags from the datapath back to the sequencer
    typedef struct packed {
        logic item_in;
        logic bad_req;
        logic scan_more;
        logic out_full;
    } seq_flags_t;

    // Microprogram step addresses
    localparam logic [PC_W-1:0] PC_WAIT    = 3'd0;
    localparam logic [PC_W-1:0] PC_CHECK   = 3'd1;
    localparam logic [PC_W-1:0] PC_SCAN    = 3'd2;
    localparam logic [PC_W-1:0] PC_RESOLVE = 3'd3;
    localparam logic [PC_W-1:0] PC_COMMIT  = 3'd4;
    localparam logic [PC_W-1:0] PC_RETURN  = 3'd5;

    // Microprogram: taken branch goes to target, otherwise to the next step
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        case (pc)
            PC_WAIT:    cw = '{take: 1'b1, uop: UOP_NONE,    cond: COND_NO_ITEM,   target: PC_WAIT};
            PC_CHECK:   cw = '{take: 1'b0, uop: UOP_CLEAR,   cond: COND_BAD_REQ,   target: PC_COMMIT};
            PC_SCAN:    cw = '{take: 1'b0, uop: UOP_SCAN,    cond: COND_SCAN_MORE, target: PC_SCAN};
            PC_RESOLVE: cw = '{take: 1'b0, uop: UOP_RESOLVE, cond: COND_NEVER,     target: PC_WAIT};
            PC_COMMIT:  cw = '{take: 1'b0, uop: UOP_COMMIT,  cond: COND_OUT_FULL,  target: PC_COMMIT};
            PC_RETURN:  cw = '{take: 1'b0, uop: UOP_NONE,    cond: COND_ALWAYS,    target: PC_WAIT};
            default:    cw = '{take: 1'b0, uop: UOP_NONE,    cond: COND_ALWAYS,    target: PC_WAIT};
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/arrt_sequencer.sv
// Sequencer: step counter, microprogram read and conditional branch.
module arrt_sequencer
    import arrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  seq_flags_t flags,
    output ctrl_word_t cw
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_true;

    // Read the control word of the current step
    assign cw = ucode_rom(pc_reg);

    // Evaluate the branch condition
    always_comb begin
        case (cw.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NO_ITEM:   cond_true = !flags.item_in;
            COND_BAD_REQ:   cond_true = flags.bad_req;
            COND_SCAN_MORE: cond_true = flags.scan_more;
            COND_OUT_FULL:  cond_true = flags.out_full;
            default:        cond_true = 1'b1;
        endcase
    end

    // Branch or advance
    assign pc_next = cond_true ? cw.target : pc_reg + PC_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> rtl/arrt_datapath.sv
// Datapath: request latch, range table, slot scan, resolve, commit and result register.
module arrt_datapath
    import arrt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_word_t            cw,
    output seq_flags_t            flags,
    input  logic                  s_tvalid,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // Latched request
    logic [CMD_W-1:0]     cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LEN_BITS-1:0]  len_reg;
    logic                 ok_reg;
    logic [KEY_W-1:0]     key_b_reg;

    // Range table
    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [ADDR_BITS-1:0] base_reg [ENTRIES];
    logic [LEN_BITS-1:0]  size_reg [ENTRIES];

    // Scan state
    logic [SLOT_W-1:0]    idx_reg;
    logic                 have_a_reg, have_b_reg, have_f_reg;
    logic [SLOT_W-1:0]    sa_reg, sb_reg, sf_reg;
    logic [ADDR_BITS-1:0] base_a_reg, base_b_reg;
    logic [LEN_BITS-1:0]  len_a_reg, len_b_reg;
    logic                 hit_a_reg, hit_b_reg;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic                 hit_reg, hit_next;
    logic [ADDR_BITS-1:0] fbase_reg, fbase_next;
    logic [LEN_BITS-1:0]  flen_reg, flen_next;
    logic [FSLOT_W-1:0]   fslot_reg, fslot_next;

    logic                 accept;
    logic                 out_full;
    logic                 do_commit;
    logic                 do_scan;
    logic                 bad_req;
    logic                 do_insert;
    logic                 do_free;
    logic [KEY_W-1:0]     key_a;
    logic                 rd_valid;
    logic [ADDR_BITS-1:0] rd_base;
    logic [LEN_BITS-1:0]  rd_len;
    logic                 take_a, take_b;

    assign accept    = s_tvalid && cw.take;
    assign out_full  = out_valid_reg && !m_tready;
    assign do_commit = (cw.uop == UOP_COMMIT) && !out_full;
    assign do_scan   = (cw.uop == UOP_SCAN);
    assign key_a     = KEY_W'(addr_reg);

    // Flag malformed requests: unknown command, or register with null address or length
    assign bad_req = (cmd_reg != CMD_REGISTER && cmd_reg != CMD_LOOKUP && cmd_reg != CMD_FREE)
                  || (cmd_reg == CMD_REGISTER && (addr_reg == '0 || len_reg == '0));

    assign flags = '{item_in:   s_tvalid,
                     bad_req:   bad_req,
                     scan_more: idx_reg != SLOT_W'(ENTRIES - 1),
                     out_full:  out_full};

    // Read one table entry per cycle at the scan index
    assign rd_valid = valid_reg[idx_reg];
    assign rd_base  = base_reg[idx_reg];
    assign rd_len   = size_reg[idx_reg];

    // Keep the greatest base not above each key; the lowest slot wins on a tie
    assign take_a = rd_valid && (KEY_W'(rd_base) <= key_a)
                 && (!have_a_reg || rd_base > base_a_reg);
    assign take_b = rd_valid && (KEY_W'(rd_base) <= key_b_reg)
                 && (!have_b_reg || rd_base > base_b_reg);

    // Latch the request and run the scan
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[ADDR_BITS-1:0];
            len_reg  <= s_tdata[ADDR_BITS +: LEN_BITS];
            ok_reg   <= s_tdata[ADDR_BITS + LEN_BITS];
        end
        if (cw.uop == UOP_CLEAR) begin
            key_b_reg  <= KEY_W'(addr_reg) + KEY_W'(len_reg) - KEY_W'(1);
            idx_reg    <= '0;
            have_a_reg <= 1'b0;
            have_b_reg <= 1'b0;
            have_f_reg <= 1'b0;
        end
        if (do_scan) begin
            if (flags.scan_more) begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (take_a) begin
                have_a_reg <= 1'b1;
                sa_reg     <= idx_reg;
                base_a_reg <= rd_base;
                len_a_reg  <= rd_len;
            end
            if (take_b) begin
                have_b_reg <= 1'b1;
                sb_reg     <= idx_reg;
                base_b_reg <= rd_base;
                len_b_reg  <= rd_len;
            end
            if (!rd_valid && !have_f_reg) begin
                have_f_reg <= 1'b1;
                sf_reg     <= idx_reg;
            end
        end
        // Hit when the key is nonzero and lies below the end of the chosen entry
        if (cw.uop == UOP_RESOLVE) begin
            hit_a_reg <= have_a_reg && (key_a != '0)
                      && (key_a < KEY_W'(base_a_reg) + KEY_W'(len_a_reg));
            hit_b_reg <= have_b_reg && (key_b_reg != '0)
                      && (key_b_reg < KEY_W'(base_b_reg) + KEY_W'(len_b_reg));
        end
    end

    // Classify the request and build the result item
    always_comb begin
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        st_next        = st_reg;
        hit_next       = hit_reg;
        fbase_next     = fbase_reg;
        flen_next      = flen_reg;
        fslot_next     = fslot_reg;
        do_insert      = 1'b0;
        do_free        = 1'b0;
        if (do_commit) begin
            out_valid_next = 1'b1;
            st_next        = ST_BADARG;
            hit_next       = 1'b0;
            fbase_next     = '0;
            flen_next      = '0;
            fslot_next     = '0;
            if (!bad_req) begin
                case (cmd_reg)
                    CMD_LOOKUP, CMD_FREE: begin
                        if (hit_a_reg) begin
                            st_next    = ST_OK;
                            hit_next   = 1'b1;
                            fbase_next = base_a_reg;
                            flen_next  = len_a_reg;
                            fslot_next = FSLOT_W'(sa_reg);
                            if (cmd_reg == CMD_FREE) begin
                                do_free             = 1'b1;
                                valid_next[sa_reg]  = 1'b0;
                            end
                        end else begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                    CMD_REGISTER: begin
                        if (hit_a_reg) begin
                            if (hit_b_reg && sa_reg == sb_reg) begin
                                st_next = ST_OK;
                            end else if (hit_b_reg) begin
                                st_next = ST_OVERLAP;
                            end else begin
                                st_next = ST_INUSE;
                            end
                            hit_next   = 1'b1;
                            fbase_next = base_a_reg;
                            flen_next  = len_a_reg;
                            fslot_next = FSLOT_W'(sa_reg);
                        end else if (hit_b_reg) begin
                            st_next    = ST_BADSIZE;
                            hit_next   = 1'b1;
                            fbase_next = base_b_reg;
                            flen_next  = len_b_reg;
                            fslot_next = FSLOT_W'(sb_reg);
                        end else if (!ok_reg || !have_f_reg) begin
                            st_next = ST_NOMEM;
                        end else begin
                            st_next            = ST_OK;
                            fslot_next         = FSLOT_W'(sf_reg);
                            do_insert          = 1'b1;
                            valid_next[sf_reg] = 1'b1;
                        end
                    end
                    default: begin
                        st_next = ST_BADARG;
                    end
                endcase
            end
        end
    end

    // Write a new range into the free slot
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            base_reg[sf_reg] <= addr_reg;
            size_reg[sf_reg] <= len_reg;
        end
    end

    // Hold control state and the result item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
        st_reg    <= st_next;
        hit_reg   <= hit_next;
        fbase_reg <= fbase_next;
        flen_reg  <= flen_next;
        fslot_reg <= fslot_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({fslot_reg, flen_reg, fbase_reg, hit_reg, st_reg});

    // An insert only ever fills a slot that was free
    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |-> !valid_reg[sf_reg])
        else $error("insert into an occupied slot");

    // A freed slot is invalid afterwards
    a_free_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        do_free |=> !valid_reg[$past(sa_reg)])
        else $error("freed slot still valid");

    // A result item appears only from a commit step
    a_out_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(do_commit))
        else $error("result raised without commit");

    // Resolve follows a scan that reached the last slot
    a_scan_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.uop == UOP_RESOLVE) |-> (idx_reg == SLOT_W'(ENTRIES - 1)))
        else $error("resolve before the scan covered every slot");

    // No commit is taken while the result register is still full
    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        do_commit |-> (!out_valid_reg || m_tready))
        else $error("commit overwrote a pending result");

endmodule

>>> rtl/address_range_registration_table.sv
// Top level: address range registration table, microcoded sequencer plus datapath.
//
//  channel  dir  ports                               payload (lowest bit up)
//  s_       in   s_tvalid s_tready s_tdata s_tuser   tdata: address, length, alloc_ok
//                                                    tuser: command
//  m_       out  m_tvalid m_tready m_tdata           tdata: status, hit, found_base,
//                                                           found_length, found_slot
//
//  Every accepted request, malformed or not, gives exactly one result item.
//  A valid request runs the wait, check, scan, resolve, commit and return steps, with
//  the scan loop reading one table slot per cycle for both range ends.
//  A malformed request skips the scan and resolve steps.
//  Reset (aresetn low, synchronous) empties the table and drops any pending result.
//  The next item is taken while a result waits; a stalled m_ side holds the commit step.
module address_range_registration_table
    import arrt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // address, length, alloc_ok, zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status, hit, found_base, found_length, found_slot
);

    ctrl_word_t cw;
    seq_flags_t flags;

    arrt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cw      (cw)
    );

    arrt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cw       (cw),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Take an item only in the wait step of the program
    assign s_tready = cw.take;

endmodule
